FILE: hw/rtl/ptq_pkg.sv
// shared types and constants for the priority ticket queue
// no dependencies; imported by priority_ticket_queue_core
package ptq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // priority given to a freshly inserted ticket, and the priority value that set priority rejects
  localparam logic [1:0] PRIO_BASE = 2'd1;
  localparam logic [1:0] PRIO_NONE = 2'd0;

  // command codes
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_SET_PRIO = 2'd1,
    OP_POP      = 2'd2,
    OP_SEARCH   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_BADPRIO  = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CK,
    S_POP_CK,
    S_SHIFT_DN_RD,
    S_SHIFT_DN_WR,
    S_SLOT_RD,
    S_SLOT_CK,
    S_SHIFT_UP_RD,
    S_SHIFT_UP_WR,
    S_PLACE,
    S_DONE
  } state_t;

  // one queue slot
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  prio;
    logic [31:0] stamp;
  } entry_t;

  // command word
  typedef struct packed {
    op_t         op;
    logic [31:0] ticket_id;
    logic [1:0]  new_priority;
    logic [31:0] now_stamp;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t          status;
    logic [31:0]      out_id;
    logic [1:0]       out_priority;
    logic [31:0]      out_stamp;
    logic [CNT_W-1:0] occupancy;
  } out_word_t;

endpackage

FILE: hw/rtl/priority_ticket_queue_core.sv
// priority ticket queue: ordered slot memory walked by one compare/shift sequencer
// depends on ptq_pkg
//
// insert and search scan the held slots for the id; pop shifts the held slots down;
// set priority scans the queue twice;
// empty pop and bad priority go straight to done without a scan
// throughput: one command at a time, the next taken the cycle after its result word loads;
// a stalled result word holds the sequencer in done
// reset: entry count cleared, sequencer idle, no result pending; slot contents unset
module priority_ticket_queue_core
  import ptq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t           state_r, state_nxt;
  in_word_t         cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_word_t        res_r, res_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             out_valid_r, out_valid_nxt;

  // slot memory
  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             in_acc;
  logic             res_free;
  logic             at_end;
  logic             shift_end;
  logic             slot_hit;
  logic             id_hit;
  logic             goes_before;
  logic             full;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_m1;
  entry_t           new_entry;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign res_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // compare unit shared by all passes
  assign idx_p1      = idx_r + CNT_W'(1);
  assign idx_m1      = idx_r - CNT_W'(1);
  assign at_end      = (idx_r == count_r);
  assign shift_end   = (idx_p1 >= count_r);
  assign slot_hit    = (idx_r == slot_r);
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign id_hit      = (rd_data_r.id == cmd_r.ticket_id);
  assign goes_before = (cmd_r.new_priority > rd_data_r.prio) ||
                       ((cmd_r.new_priority == rd_data_r.prio) &&
                        (cmd_r.now_stamp < rd_data_r.stamp));
  assign new_entry   = '{id: cmd_r.ticket_id, prio: cmd_r.new_priority,
                         stamp: cmd_r.now_stamp};

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_word.op)
            OP_INSERT, OP_SEARCH: state_nxt = S_FIND_RD;
            OP_SET_PRIO: state_nxt = (in_word.new_priority == PRIO_NONE) ? S_DONE : S_FIND_RD;
            OP_POP:      state_nxt = (count_r == '0) ? S_DONE : S_POP_CK;
          endcase
        end
      end
      S_FIND_RD:     state_nxt = at_end ? S_DONE : S_FIND_CK;
      S_FIND_CK: begin
        if (!id_hit) begin
          state_nxt = S_FIND_RD;
        end else if (cmd_r.op == OP_SET_PRIO) begin
          state_nxt = S_SHIFT_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_CK:      state_nxt = S_SHIFT_DN_RD;
      S_SHIFT_DN_RD: begin
        if (!shift_end) begin
          state_nxt = S_SHIFT_DN_WR;
        end else begin
          state_nxt = (cmd_r.op == OP_POP) ? S_DONE : S_SLOT_RD;
        end
      end
      S_SHIFT_DN_WR: state_nxt = S_SHIFT_DN_RD;
      S_SLOT_RD:     state_nxt = at_end ? S_SHIFT_UP_RD : S_SLOT_CK;
      S_SLOT_CK:     state_nxt = goes_before ? S_SHIFT_UP_RD : S_SLOT_RD;
      S_SHIFT_UP_RD: state_nxt = slot_hit ? S_PLACE : S_SHIFT_UP_WR;
      S_SHIFT_UP_WR: state_nxt = S_SHIFT_UP_RD;
      S_PLACE:       state_nxt = S_DONE;
      S_DONE:        state_nxt = res_free ? S_IDLE : S_DONE;
      default:       state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = rd_data_r;
    rd_addr       = idx_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        // head is read ahead for pop
        rd_addr = '0;
        if (in_acc) begin
          cmd_nxt = in_word;
          idx_nxt = '0;
          res_nxt = '{status: STAT_OK, out_id: '0, out_priority: PRIO_NONE,
                      out_stamp: '0, occupancy: '0};
          if (in_word.op == OP_SET_PRIO && in_word.new_priority == PRIO_NONE) begin
            res_nxt.status = STAT_BADPRIO;
          end
          if (in_word.op == OP_POP && count_r == '0) begin
            res_nxt.status = STAT_EMPTY;
          end
        end
      end
      S_FIND_RD: begin
        // id absent: insert appends at the tail unless full, others report not found
        if (at_end) begin
          if (cmd_r.op != OP_INSERT) begin
            res_nxt.status = STAT_NOTFOUND;
          end else if (full) begin
            res_nxt.status = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            wr_data   = '{id: cmd_r.ticket_id, prio: PRIO_BASE, stamp: cmd_r.now_stamp};
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      S_FIND_CK: begin
        if (!id_hit) begin
          idx_nxt = idx_p1;
        end else if (cmd_r.op == OP_INSERT) begin
          res_nxt.status = STAT_DUP;
        end else if (cmd_r.op == OP_SEARCH) begin
          res_nxt.out_id       = rd_data_r.id;
          res_nxt.out_priority = rd_data_r.prio;
          res_nxt.out_stamp    = rd_data_r.stamp;
        end
      end
      S_POP_CK: begin
        res_nxt.out_id       = rd_data_r.id;
        res_nxt.out_priority = rd_data_r.prio;
        res_nxt.out_stamp    = rd_data_r.stamp;
      end
      S_SHIFT_DN_RD: begin
        // close the gap at idx
        rd_addr = idx_p1[IDX_W-1:0];
        if (shift_end) begin
          count_nxt = count_r - CNT_W'(1);
          idx_nxt   = '0;
        end
      end
      S_SHIFT_DN_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_p1;
      end
      S_SLOT_RD: begin
        if (at_end) begin
          slot_nxt = idx_r;
          idx_nxt  = count_r;
        end
      end
      S_SLOT_CK: begin
        if (goes_before) begin
          slot_nxt = idx_r;
          idx_nxt  = count_r;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_SHIFT_UP_RD: begin
        // open a gap at the slot, from the tail down
        rd_addr = idx_m1[IDX_W-1:0];
      end
      S_SHIFT_UP_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_m1;
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        wr_addr   = slot_r[IDX_W-1:0];
        wr_data   = new_entry;
        count_nxt = count_r + CNT_W'(1);
      end
      S_DONE: begin
        if (res_free) begin
          out_word_nxt           = res_r;
          out_word_nxt.occupancy = count_r;
          out_valid_nxt          = 1'b1;
        end
      end
      default: begin
        rd_addr = idx_r[IDX_W-1:0];
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // occupancy never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // one command changes occupancy by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + CNT_W'(1) ||
                      count_r + CNT_W'(1) == $past(count_r)))
    else $error("entry count jumped");

  // a new result word comes only out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word raised outside done state");

  // shift-down writes stay inside the held slots
  a_shift_dn_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_DN_WR |-> idx_p1 < count_r)
    else $error("shift-down write past the tail");

endmodule
